// ===== rtl/scpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor chain packet relay package
// Transaction types, protocol bytes and item formatting shared by the relay.
// ----------------------------------------------------------------------------
package scpr_pkg;

   localparam int unsigned ADDRESS_COUNT_DEFAULT = 20;
   localparam int unsigned MAX_RESULTS           = 12;
   localparam int unsigned ITEM_BYTES            = 5;
   localparam int unsigned ACC_W                 = 12;
   localparam int unsigned FIELD_W               = 6;
   localparam int unsigned OWN_ADDR_W            = 5;
   localparam int unsigned PEND_W                = 4;

   localparam logic [7:0]            START_BYTE        = 8'h80;
   localparam logic [7:0]            END_BYTE          = 8'h40;
   localparam logic [7:0]            INSTANCE_MAX      = 8'd20;
   localparam logic [OWN_ADDR_W-1:0] OWN_ADDRESS_RESET = 5'd10;

   typedef struct packed {
      logic        kind;
      logic [7:0]  rx_byte;
      logic [11:0] reading_a;
      logic [11:0] reading_b;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_type;

   typedef logic [ITEM_BYTES-1:0][7:0] item_type;

   function automatic item_type item_bytes(input logic [ACC_W-1:0] addr,
                                           input logic [7:0]       inst,
                                           input logic [ACC_W-1:0] data);
      item_type b;
      b[0] = {2'b00, addr[ACC_W-1:FIELD_W]};
      b[1] = {2'b00, addr[FIELD_W-1:0]};
      b[2] = inst;
      b[3] = {2'b00, data[ACC_W-1:FIELD_W]};
      b[4] = {2'b00, data[FIELD_W-1:0]};
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/sensor_chain_packet_relay_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor chain packet relay
// Parses a daisy-chain sensor byte stream, renumbers and relays valid items,
// and inserts the local sensor's own two readings into the chain.
// ----------------------------------------------------------------------------
// Usage:
// The request channel takes one transaction per accepted cycle: either a
// received stream byte or a trigger for a complete local packet, together
// with the two current local readings. Each request is parsed in the cycle it
// is accepted and produces zero to twelve bytes on the response channel, one
// byte per cycle, starting in the next cycle. The final byte of a request is
// flagged with last. Requests that produce no bytes can be accepted every
// cycle while no byte is pending. After a request that produces bytes, the
// next request is accepted in the cycle its last byte is taken, limited by
// the twelve-entry output shift buffer.
// When the receiver stalls, the current byte holds and requests stall while
// any byte is pending. The own address register is written through the csr
// port; the user writes it only while the block is idle, which the block
// does not enforce. Synchronous reset empties the output buffer, idles the
// parser, clears all instance counters and sets the own address to ten.
// ----------------------------------------------------------------------------
module sensor_chain_packet_relay_unit #(
   parameter int unsigned ADDRESS_COUNT = scpr_pkg::ADDRESS_COUNT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire scpr_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output scpr_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_wr_en,
   input  wire logic [scpr_pkg::OWN_ADDR_W-1:0]     csr_wr_data
);

   localparam int unsigned IDX_W = (ADDRESS_COUNT > 1) ? $clog2(ADDRESS_COUNT) : 1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR_HI,
      PH_ADDR_LO,
      PH_INST,
      PH_DATA_HI,
      PH_DATA_LO
   } phase_type;

   typedef logic [scpr_pkg::MAX_RESULTS-1:0][7:0] buf_type;

   phase_type                           phase_ff, phase_in;
   logic [scpr_pkg::ACC_W-1:0]          addr_acc_ff, addr_acc_in;
   logic [scpr_pkg::ACC_W-1:0]          data_acc_ff, data_acc_in;
   logic                                start_sent_ff, start_sent_in;
   logic [7:0]                          count_ff [ADDRESS_COUNT];
   logic [7:0]                          count_in [ADDRESS_COUNT];
   logic [scpr_pkg::OWN_ADDR_W-1:0]     own_addr_ff, own_addr_in;
   buf_type                             buf_ff, buf_in;
   logic [scpr_pkg::PEND_W-1:0]         pend_ff, pend_in;

   logic                                req_take, rsp_take;
   logic                                is_trig, is_start, is_end, own_req, relay;
   logic [scpr_pkg::ACC_W-1:0]          sel_addr, relay_data;
   logic                                sel_ok;
   logic [IDX_W-1:0]                    sel_idx;
   logic [7:0]                          inst_a, inst_b;
   scpr_pkg::item_type                  own_item_a, own_item_b, relay_item;
   buf_type                             res_bytes;
   logic [scpr_pkg::PEND_W-1:0]         res_n;

   assign rsp_valid           = (pend_ff != '0);
   assign rsp_payload.tx_byte = buf_ff[0];
   assign rsp_payload.last    = (pend_ff == scpr_pkg::PEND_W'(1));
   assign rsp_take            = rsp_valid && !rsp_stall;
   assign req_stall           = (pend_ff > scpr_pkg::PEND_W'(1)) ||
                                ((pend_ff == scpr_pkg::PEND_W'(1)) && rsp_stall);
   assign req_take            = req_valid && !req_stall;

   assign is_trig  = req_payload.kind;
   assign is_start = !req_payload.kind && (req_payload.rx_byte == scpr_pkg::START_BYTE);
   assign is_end   = !req_payload.kind && (req_payload.rx_byte == scpr_pkg::END_BYTE);
   assign own_req  = is_trig || (is_end && (phase_ff == PH_ADDR_HI));
   assign relay    = !req_payload.kind && !is_start && !is_end && (phase_ff == PH_DATA_LO);

   assign sel_addr   = relay ? addr_acc_ff : scpr_pkg::ACC_W'(own_addr_ff);
   assign sel_ok     = (sel_addr < scpr_pkg::ACC_W'(ADDRESS_COUNT));
   assign sel_idx    = sel_addr[IDX_W-1:0];
   assign inst_a     = sel_ok ? count_ff[sel_idx] : '0;
   assign inst_b     = sel_ok ? (inst_a + 8'd1) : '0;
   assign relay_data = {data_acc_ff[scpr_pkg::ACC_W-1:scpr_pkg::FIELD_W],
                        req_payload.rx_byte[scpr_pkg::FIELD_W-1:0]};

   assign own_item_a = scpr_pkg::item_bytes(sel_addr, inst_a, req_payload.reading_a);
   assign own_item_b = scpr_pkg::item_bytes(sel_addr, inst_b, req_payload.reading_b);
   assign relay_item = scpr_pkg::item_bytes(sel_addr, inst_a, relay_data);

   always_comb begin
      res_bytes = '0;
      res_n     = '0;
      if (is_trig) begin
         res_bytes[0]    = scpr_pkg::START_BYTE;
         res_bytes[5:1]  = own_item_a;
         res_bytes[10:6] = own_item_b;
         res_bytes[11]   = scpr_pkg::END_BYTE;
         res_n           = scpr_pkg::PEND_W'(12);
      end else if (own_req) begin
         res_bytes[4:0]  = own_item_a;
         res_bytes[9:5]  = own_item_b;
         res_bytes[10]   = scpr_pkg::END_BYTE;
         res_n           = scpr_pkg::PEND_W'(11);
      end else if (relay) begin
         if (!start_sent_ff) begin
            res_bytes[0]   = scpr_pkg::START_BYTE;
            res_bytes[5:1] = relay_item;
            res_n          = sel_ok ? scpr_pkg::PEND_W'(6) : scpr_pkg::PEND_W'(1);
         end else begin
            res_bytes[4:0] = relay_item;
            res_n          = sel_ok ? scpr_pkg::PEND_W'(5) : '0;
         end
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      addr_acc_in   = addr_acc_ff;
      data_acc_in   = data_acc_ff;
      start_sent_in = start_sent_ff;
      count_in      = count_ff;
      own_addr_in   = csr_wr_en ? csr_wr_data : own_addr_ff;
      buf_in        = buf_ff;
      pend_in       = pend_ff;

      if (rsp_take) begin
         buf_in  = {8'h00, buf_ff[scpr_pkg::MAX_RESULTS-1:1]};
         pend_in = pend_ff - scpr_pkg::PEND_W'(1);
      end

      if (req_take) begin
         buf_in  = res_bytes;
         pend_in = res_n;

         if (is_trig || is_start) begin
            for (int i = 0; i < ADDRESS_COUNT; i++) begin
               count_in[i] = '0;
            end
         end else if (own_req && sel_ok) begin
            count_in[sel_idx] = inst_a + 8'd2;
         end else if (relay && sel_ok) begin
            count_in[sel_idx] = inst_b;
         end

         if (is_start) begin
            phase_in      = PH_ADDR_HI;
            start_sent_in = 1'b0;
         end else if (is_end) begin
            phase_in = PH_IDLE;
         end else if (!is_trig) begin
            unique case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_ADDR_HI: begin
                  addr_acc_in = {req_payload.rx_byte[scpr_pkg::FIELD_W-1:0],
                                 scpr_pkg::FIELD_W'(0)};
                  phase_in    = PH_ADDR_LO;
               end
               PH_ADDR_LO: begin
                  addr_acc_in = {addr_acc_ff[scpr_pkg::ACC_W-1:scpr_pkg::FIELD_W],
                                 req_payload.rx_byte[scpr_pkg::FIELD_W-1:0]};
                  phase_in    = PH_INST;
               end
               PH_INST: begin
                  phase_in = (req_payload.rx_byte > scpr_pkg::INSTANCE_MAX) ?
                             PH_IDLE : PH_DATA_HI;
               end
               PH_DATA_HI: begin
                  data_acc_in = {req_payload.rx_byte[scpr_pkg::FIELD_W-1:0],
                                 scpr_pkg::FIELD_W'(0)};
                  phase_in    = PH_DATA_LO;
               end
               PH_DATA_LO: begin
                  data_acc_in   = relay_data;
                  start_sent_in = 1'b1;
                  phase_in      = PH_ADDR_HI;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         phase_ff      <= PH_IDLE;
         addr_acc_ff   <= '0;
         data_acc_ff   <= '0;
         start_sent_ff <= 1'b0;
         own_addr_ff   <= scpr_pkg::OWN_ADDRESS_RESET;
         pend_ff       <= '0;
         for (int i = 0; i < ADDRESS_COUNT; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         phase_ff      <= phase_in;
         addr_acc_ff   <= addr_acc_in;
         data_acc_ff   <= data_acc_in;
         start_sent_ff <= start_sent_in;
         own_addr_ff   <= own_addr_in;
         pend_ff       <= pend_in;
         count_ff      <= count_in;
      end
   end

`ifndef SYNTH
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= scpr_pkg::PEND_W'(scpr_pkg::MAX_RESULTS))
      else $error("Output buffer holds more bytes than one request can produce.");

   a_trig_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_payload.kind) |=>
         (rsp_valid && rsp_payload.tx_byte == scpr_pkg::START_BYTE))
      else $error("Trigger transaction did not begin with a start byte.");

   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      (req_take && is_start) |=> (count_ff[0] == '0 && phase_ff == PH_ADDR_HI))
      else $error("Start byte did not clear the counters and restart the parser.");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_take && rsp_valid) |-> (pend_ff == scpr_pkg::PEND_W'(1) && rsp_take))
      else $error("Request accepted while earlier response bytes were still pending.");
`endif

endmodule
`default_nettype wire
